// ===== src/bfiq_pkg.sv =====
// ----------------------------------------------------------------------------
// bfiq_pkg: shared constants and types for the Bloom filter insert/query block
// Field widths, register indexes, word kinds, hashing constants and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bfiq_pkg;

    // Default sizing of the bit store and the per-word index count
    localparam int DEF_MAX_BITS   = 65536;
    localparam int DEF_MAX_HASHES = 16;

    // Digest layout
    localparam int DIGEST_WORDS = 8;
    localparam int WORD_W       = 64;
    localparam logic [WORD_W-1:0] GOLDEN = 64'h9E37_79B9_7F4A_7C15;

    // Word kinds
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Configuration registers
    localparam int BIT_COUNT_W  = 17;
    localparam int HASH_COUNT_W = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 17;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = 2'd1;
    localparam logic [BIT_COUNT_W-1:0]  BIT_COUNT_RST  = 17'd64;
    localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RST = 5'd7;

    // Bit store row organization
    localparam int ROW_BITS = 64;
    localparam int ROW_LOG  = 6;

    // Remainder unit: bits of the dividend consumed per cycle
    localparam int MOD_RADIX = 8;
    localparam int MOD_STEPS = WORD_W / MOD_RADIX;
    localparam int STEP_W    = $clog2(MOD_STEPS);

    // Controller to datapath commands
    typedef struct packed {
        logic clr;       // write one zero row of the clearing pass
        logic start;     // capture the accepted word
        logic load;      // form the next hash value
        logic mod_step;  // advance the remainder by one digit
        logic rd;        // read the indexed row
        logic upd;       // test or set the indexed bit
        logic out_load;  // place the query result in the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;  // clearing pass is on its last row
        logic mod_last;  // remainder is on its last digit
        logic idx_last;  // current index is the last one of the word
        logic is_query;  // word in flight is a query
        logic out_busy;  // output register holds a result not yet taken
    } t_sts;

endpackage

// ===== src/bfiq_if.sv =====
// ----------------------------------------------------------------------------
// bfiq_if: valid/ready channels of the Bloom filter block
// Request channel carries the kind and the eight digest words; response
// channel carries the membership answer.
// ----------------------------------------------------------------------------
interface bfiq_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [63:0] digest_word_0;
    logic [63:0] digest_word_1;
    logic [63:0] digest_word_2;
    logic [63:0] digest_word_3;
    logic [63:0] digest_word_4;
    logic [63:0] digest_word_5;
    logic [63:0] digest_word_6;
    logic [63:0] digest_word_7;

    modport source (
        output valid, kind,
        output digest_word_0, digest_word_1, digest_word_2, digest_word_3,
        output digest_word_4, digest_word_5, digest_word_6, digest_word_7,
        input  ready
    );

    modport sink (
        input  valid, kind,
        input  digest_word_0, digest_word_1, digest_word_2, digest_word_3,
        input  digest_word_4, digest_word_5, digest_word_6, digest_word_7,
        output ready
    );
endinterface

interface bfiq_rsp_if;
    logic valid;
    logic ready;
    logic might_contain;

    modport source (
        output valid, might_contain,
        input  ready
    );

    modport sink (
        input  valid, might_contain,
        output ready
    );
endinterface

// ===== src/bloom_filter_insert_query.sv =====
// ----------------------------------------------------------------------------
// bloom_filter_insert_query: Bloom filter bit store with add and query
// Derives up to MAX_HASHES indices per word from a 512-bit digest, reduces
// each modulo the configured bit count and sets or tests that bit.
// ----------------------------------------------------------------------------
//   channel   dir  handshake          payload
//   i_req     in   valid/ready        kind, digest_word_0 .. digest_word_7
//   o_rsp     out  valid/ready        might_contain (queries only)
//   i_cfg_*   in   write enable only  index, 17-bit data
//
// One word at a time: i_req.ready stays low from acceptance until the word is
// finished with all k indices, k being the effective hash count. Per index a
// hash is formed, the remainder unit reduces it (8 dividend bits a cycle), and
// then the indexed row is read and its bit tested or set.
// After reset a clearing pass writes MAX_BITS/64 rows (1024 by default), one
// per cycle, with i_req.ready low. A finished query waits while o_rsp holds an
// untaken answer; a new word is accepted while the answer waits.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query #(
    parameter int MAX_BITS   = bfiq_pkg::DEF_MAX_BITS,
    parameter int MAX_HASHES = bfiq_pkg::DEF_MAX_HASHES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bfiq_req_if.sink                          i_req,
    bfiq_rsp_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [bfiq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bfiq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bfiq_pkg::*;

    localparam int MW   = $clog2(MAX_BITS + 1);
    localparam int KW   = $clog2(MAX_HASHES + 1);
    localparam int MEXT = (MW > BIT_COUNT_W) ? MW : BIT_COUNT_W;
    localparam int KEXT = (KW > HASH_COUNT_W) ? KW : HASH_COUNT_W;

    logic [BIT_COUNT_W-1:0]  r_bit_count;
    logic [HASH_COUNT_W-1:0] r_hash_count;
    logic [MEXT-1:0]         w_bits_ext;
    logic [KEXT-1:0]         w_hash_ext;
    logic [MW-1:0]           w_m_eff;
    logic [KW-1:0]           w_k_eff;

    logic [DIGEST_WORDS-1:0][WORD_W-1:0] w_digest;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count  <= BIT_COUNT_RST;
            r_hash_count <= HASH_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BIT_COUNT:  r_bit_count  <= i_cfg_data[BIT_COUNT_W-1:0];
                REG_HASH_COUNT: r_hash_count <= i_cfg_data[HASH_COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the bit count and hash count into their usable ranges
    assign w_bits_ext = MEXT'(r_bit_count);
    assign w_hash_ext = KEXT'(r_hash_count);

    always_comb begin
        if (w_bits_ext == '0) begin
            w_m_eff = MW'(1);
        end else if (w_bits_ext > MEXT'(MAX_BITS)) begin
            w_m_eff = MW'(MAX_BITS);
        end else begin
            w_m_eff = MW'(w_bits_ext);
        end
    end

    always_comb begin
        if (w_hash_ext == '0) begin
            w_k_eff = KW'(1);
        end else if (w_hash_ext > KEXT'(MAX_HASHES)) begin
            w_k_eff = KW'(MAX_HASHES);
        end else begin
            w_k_eff = KW'(w_hash_ext);
        end
    end

    assign w_digest = {i_req.digest_word_7, i_req.digest_word_6,
                       i_req.digest_word_5, i_req.digest_word_4,
                       i_req.digest_word_3, i_req.digest_word_2,
                       i_req.digest_word_1, i_req.digest_word_0};

    assign i_req.ready = w_in_ready;

    bfiq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bfiq_dp #(
        .MAX_BITS   (MAX_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_kind      (i_req.kind),
        .i_digest    (w_digest),
        .i_m_eff     (w_m_eff),
        .i_k_eff     (w_k_eff),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_out_data  (o_rsp.might_contain)
    );

    // One word in flight: no second accept right after the first
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("word accepted while another is in flight");

    // No accept during the clearing pass
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr |-> !i_req.ready)
        else $error("ready raised during clearing pass");

    // A waiting answer is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !w_sts.out_busy)
        else $error("answer loaded over an untaken answer");

    // Only queries produce answers
    a_query_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.is_query)
        else $error("answer produced for an add");

endmodule

// ===== src/bfiq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfiq_ctrl: sequencer of the Bloom filter block
// Runs the clearing pass after reset, then steps each word through its
// indices: form hash, reduce, read row, test or set, and deliver the answer.
// ----------------------------------------------------------------------------
module bfiq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bfiq_pkg::t_sts  i_sts,
    output bfiq_pkg::t_cmd  o_cmd
);
    import bfiq_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b000_0001,
        S_IDLE  = 7'b000_0010,
        S_LOAD  = 7'b000_0100,
        S_MOD   = 7'b000_1000,
        S_READ  = 7'b001_0000,
        S_UPD   = 7'b010_0000,
        S_DONE  = 7'b100_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_MOD;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.idx_last ? S_DONE : S_LOAD;
            end
            S_DONE: begin
                // adds finish silently; queries wait for a free output slot
                if (!i_sts.is_query) begin
                    n_state = S_IDLE;
                end else if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/bfiq_dp.sv =====
// ----------------------------------------------------------------------------
// bfiq_dp: datapath of the Bloom filter block
// Holds the captured word, the hash mixer, the digit-serial remainder unit,
// the row-organized bit store and the output register.
// ----------------------------------------------------------------------------
module bfiq_dp #(
    parameter int MAX_BITS   = bfiq_pkg::DEF_MAX_BITS,
    parameter int MAX_HASHES = bfiq_pkg::DEF_MAX_HASHES
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  bfiq_pkg::t_cmd                                         i_cmd,
    output bfiq_pkg::t_sts                                         o_sts,
    input  logic                                                   i_kind,
    input  logic [bfiq_pkg::DIGEST_WORDS-1:0][bfiq_pkg::WORD_W-1:0] i_digest,
    input  logic [$clog2(MAX_BITS+1)-1:0]                          i_m_eff,
    input  logic [$clog2(MAX_HASHES+1)-1:0]                        i_k_eff,
    input  logic                                                   i_out_ready,
    output logic                                                   o_out_valid,
    output logic                                                   o_out_data
);
    import bfiq_pkg::*;

    localparam int MW    = $clog2(MAX_BITS + 1);
    localparam int IW    = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int DEPTH = (MAX_BITS + ROW_BITS - 1) / ROW_BITS;
    localparam int RAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Captured word
    logic [DIGEST_WORDS-1:0][WORD_W-1:0] r_digest;
    logic                                r_kind;
    logic [MW-1:0]                       r_m;
    logic [IW-1:0]                       r_last_idx;

    // Index sequencing and hash mixing
    logic [IW-1:0]     r_idx;
    logic [WORD_W-1:0] r_golden_acc;
    logic [WORD_W-1:0] w_word;
    logic [WORD_W-1:0] w_mix;

    // Remainder unit
    logic [WORD_W-1:0] r_dvd;
    logic [MW-1:0]     r_rem;
    logic [STEP_W-1:0] r_step;
    logic [MW-1:0]     w_rem_next;
    logic [MW:0]       w_trial;

    // Bit store
    logic [ROW_BITS-1:0] r_mem [DEPTH];
    logic [ROW_BITS-1:0] r_rdata;
    logic [RAW-1:0]      r_clr_addr;
    logic [RAW-1:0]      w_row;
    logic [ROW_LOG-1:0]  w_bit;
    logic                w_we;
    logic [RAW-1:0]      w_waddr;
    logic [ROW_BITS-1:0] w_wdata;

    // Query result
    logic r_hit;
    logic r_out_valid;
    logic r_out_data;

    // Select digest word i mod 8, mix in i times the golden constant past 8
    assign w_word = r_digest[3'(r_idx)];
    assign w_mix  = (32'(r_idx) >= DIGEST_WORDS) ? r_golden_acc : '0;

    // Shift in one digit of the dividend, MSB first, with conditional subtract
    always_comb begin
        w_rem_next = r_rem;
        w_trial    = '0;
        for (int j = 0; j < MOD_RADIX; j++) begin
            w_trial = {w_rem_next, r_dvd[WORD_W-1-j]};
            if (w_trial >= {1'b0, r_m}) begin
                w_trial = w_trial - {1'b0, r_m};
            end
            w_rem_next = w_trial[MW-1:0];
        end
    end

    // Split the bit index into row and bit position
    assign w_row = RAW'(r_rem >> ROW_LOG);
    assign w_bit = r_rem[ROW_LOG-1:0];

    // Store write port: clearing pass or read-modify-write of an add
    assign w_we    = i_cmd.clr | (i_cmd.upd & ~r_kind);
    assign w_waddr = i_cmd.clr ? r_clr_addr : w_row;
    assign w_wdata = i_cmd.clr ? '0 : (r_rdata | (ROW_BITS'(1) << w_bit));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[w_row];
        end
    end

    // Advance the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + RAW'(1);
        end
    end

    // Capture the word, then walk its indices
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_digest     <= i_digest;
            r_kind       <= i_kind;
            r_m          <= i_m_eff;
            r_last_idx   <= IW'(i_k_eff - 1'b1);
            r_idx        <= '0;
            r_golden_acc <= '0;
            r_hit        <= 1'b1;
        end
        if (i_cmd.load) begin
            r_dvd  <= w_word ^ w_mix;
            r_rem  <= '0;
            r_step <= '0;
        end
        if (i_cmd.mod_step) begin
            r_dvd  <= r_dvd << MOD_RADIX;
            r_rem  <= w_rem_next;
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.upd) begin
            if (r_kind && !r_rdata[w_bit]) begin
                r_hit <= 1'b0;
            end
            r_idx        <= r_idx + IW'(1);
            r_golden_acc <= r_golden_acc + GOLDEN;
        end
    end

    // Hold the answer until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_sts.clr_last = (r_clr_addr == RAW'(DEPTH - 1));
    assign o_sts.mod_last = (r_step == STEP_W'(MOD_STEPS - 1));
    assign o_sts.idx_last = (r_idx == r_last_idx);
    assign o_sts.is_query = r_kind;
    assign o_sts.out_busy = r_out_valid & ~i_out_ready;

endmodule
